// ===== rtl/core/gerstner_wave_vertex_eval_assert.svh =====
// Assertion macros for the Gerstner wave vertex evaluator.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef GERSTNER_WAVE_VERTEX_EVAL_ASSERT_SVH
`define GERSTNER_WAVE_VERTEX_EVAL_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GWV_ASSERT_IMPL(LBL, ANT, CON) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANT) |-> (CON)) \
        else $error("gwv check failed");

// Next-cycle implication, checked outside reset.
`define GWV_ASSERT_NEXT(LBL, ANT, CON) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANT) |=> (CON)) \
        else $error("gwv check failed");

`endif

// ===== rtl/core/gwv_pkg.sv =====
// Shared constants, types and arithmetic helpers for the wave evaluator.
// No dependencies.
`default_nettype none
package gwv_pkg;

    localparam int MAX_WAVES       = 8;
    localparam int SINE_TABLE_BITS = 10;
    localparam int QUARTER         = 1 << (SINE_TABLE_BITS - 2);
    localparam int WAVE_IDX_W      = (MAX_WAVES > 1) ? $clog2(MAX_WAVES) : 1;
    localparam int WAVE_CNT_W      = $clog2(MAX_WAVES + 1);
    localparam int ACC_W           = 33 + $clog2(MAX_WAVES + 1);
    localparam int ENTRY_W         = 6 * 32;
    localparam int IN_DATA_W       = 104;
    localparam int OUT_DATA_W      = 144;

    localparam logic [63:0]        TWO_PI_Q30 = 64'd6746518852;
    localparam logic signed [31:0] TWO_PI_Q16 = 32'sd411775;
    localparam logic signed [31:0] ONE_Q16    = 32'sd65536;
    localparam logic signed [15:0] ONE_Q14    = 16'sd16384;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic CFG_TIME   = 1'b0;
    localparam logic CFG_ACTIVE = 1'b1;

    localparam logic [2:0] FLD_AMP   = 3'd0;
    localparam logic [2:0] FLD_STEEP = 3'd1;
    localparam logic [2:0] FLD_DIR_X = 3'd2;
    localparam logic [2:0] FLD_DIR_Z = 3'd3;
    localparam logic [2:0] FLD_FREQ  = 3'd4;
    localparam logic [2:0] FLD_RATE  = 3'd5;

    typedef logic [16:0] t_qtab [QUARTER + 1];

    typedef struct packed {
        logic               valid;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [31:0] uz;
    } t_wave_terms;

    typedef struct packed {
        logic busy;
        logic done;
    } t_norm_stat;

    // Quarter-wave sine, Q30 Taylor series rounded to Q16.16.
    function automatic t_qtab build_qsin();
        t_qtab       tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        for (int r = 0; r <= QUARTER; r++) begin
            x  = (64'(r) * TWO_PI_Q30) >> SINE_TABLE_BITS;
            x2 = (x * x) >> 30;
            t  = 64'd1 << 30;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd156;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd110;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
            tab[r] = 17'((((x * t) >> 30) + 64'd8192) >> 14);
        end
        return tab;
    endfunction

    localparam t_qtab QSIN = build_qsin();

    function automatic logic signed [17:0] sine_at(input logic [SINE_TABLE_BITS-1:0] k);
        logic [1:0]                 quad;
        logic [SINE_TABLE_BITS-1:0] idx;
        logic signed [17:0]         v;
        quad = k[SINE_TABLE_BITS-1 -: 2];
        idx  = {2'b00, k[SINE_TABLE_BITS-3:0]};
        if (quad[0]) begin
            idx = SINE_TABLE_BITS'(QUARTER) - idx;
        end
        v = $signed({1'b0, QSIN[idx[SINE_TABLE_BITS-2:0]]});
        return quad[1] ? -v : v;
    endfunction

    // Q16.16 product, rounded half up, saturated.
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [47:0] sh;
        p  = a * b;
        p  = p + 64'sd32768;
        sh = 48'(p >>> 16);
        if (sh > 48'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (sh < -48'sd2147483648) begin
            return 32'sh80000000;
        end
        return sh[31:0];
    endfunction

    function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(64'sd2147483647)) begin
            return 32'sh7fffffff;
        end else if (v < -ACC_W'(64'sd2147483648)) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gerstner_wave_vertex_eval.sv =====
// Gerstner wave sum vertex evaluator: top level, control and wave table.
// Depends on gwv_pkg, gwv_ram, gwv_wave_pipe, gwv_norm and the assert header.
`default_nettype none
`include "gerstner_wave_vertex_eval_assert.svh"
// A load transaction (tuser = 0) writes one field of one wave table entry with
// a read-modify-write of the table RAM (an unknown field code writes nothing)
// and returns nothing. An evaluate transaction (tuser = 1) reads one wave entry
// per cycle into a six-stage term pipeline and sums the terms over the N active
// waves. The normal is then normalized by single-bit scaling, a sum of squares,
// a bit-serial square root and bit-serial division. A new transaction is taken
// while the previous result waits on the master side.
module gerstner_wave_vertex_eval import gwv_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // wave_slot[2:0], wave_field[5:3], wave_value[37:6], pos_x[69:38],
    // pos_z[101:70], zero pad
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // operation
    input  wire logic                  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], norm_x[111:96],
    // norm_y[127:112], norm_z[143:128]
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic                  i_cfg_index,
    input  wire logic [31:0]           i_cfg_data
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_NORM = 4'b1000
    } t_state;

    t_state                  r_state;
    logic [31:0]             r_time;
    logic [3:0]              r_active;
    logic [WAVE_CNT_W-1:0]   r_count, r_issue, r_left;
    logic                    r_rd_vld;
    logic [WAVE_IDX_W-1:0]   r_ld_addr;
    logic [2:0]              r_ld_field;
    logic [31:0]             r_ld_value;
    logic                    r_ld_ok;
    logic signed [31:0]      r_px, r_pz;
    logic signed [ACC_W-1:0] r_sx, r_sy, r_sz, r_n0, r_n1, r_n2;
    logic                    r_out_vld;
    logic [OUT_DATA_W-1:0]   r_out_data;

    logic [2:0]            in_slot, in_field;
    logic [31:0]           in_value;
    logic                  in_acc, issue, out_free, out_load, norm_start, slot_ok;
    logic [WAVE_IDX_W-1:0] raddr;
    logic [ENTRY_W-1:0]    rdata, wdata;
    logic                  we;
    logic [WAVE_CNT_W-1:0] count;
    t_wave_terms           terms;
    t_norm_stat            norm_stat;
    logic signed [15:0]    nrm_x, nrm_y, nrm_z;

    assign in_slot   = i_s_axis_tdata[2:0];
    assign in_field  = i_s_axis_tdata[5:3];
    assign in_value  = i_s_axis_tdata[37:6];
    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_ok   = (7'(in_slot) < 7'(MAX_WAVES));
    assign count     = (32'(r_active) > 32'(MAX_WAVES)) ? WAVE_CNT_W'(MAX_WAVES)
                                                        : WAVE_CNT_W'(r_active);
    assign issue     = (r_state == ST_RUN) && (r_issue < r_count);
    assign raddr     = (r_state == ST_RUN) ? r_issue[WAVE_IDX_W-1:0]
                                           : WAVE_IDX_W'(in_slot);
    assign out_free  = !r_out_vld || i_m_axis_tready;
    assign out_load  = (r_state == ST_NORM) && norm_stat.done && out_free;
    assign norm_start = (r_state == ST_RUN) && (r_left == '0);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    // merge the loaded field into the entry just read
    always_comb begin
        wdata = rdata;
        we    = (r_state == ST_LOAD) && r_ld_ok;
        unique case (r_ld_field)
            FLD_AMP:   wdata[0   +: 32] = r_ld_value;
            FLD_STEEP: wdata[32  +: 32] = r_ld_value;
            FLD_DIR_X: wdata[64  +: 32] = r_ld_value;
            FLD_DIR_Z: wdata[96  +: 32] = r_ld_value;
            FLD_FREQ:  wdata[128 +: 32] = r_ld_value;
            FLD_RATE:  wdata[160 +: 32] = r_ld_value;
            default:   we = 1'b0;
        endcase
    end

    gwv_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_WAVES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_ld_addr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    gwv_wave_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_rd_vld),
        .i_entry (rdata),
        .i_px    (r_px),
        .i_pz    (r_pz),
        .i_time  (r_time),
        .o_terms (terms)
    );

    gwv_norm u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (norm_start),
        .i_nx     (r_n0),
        .i_ny     (r_n1),
        .i_nz     (r_n2),
        .o_stat   (norm_stat),
        .o_norm_x (nrm_x),
        .o_norm_y (nrm_y),
        .o_norm_z (nrm_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_time    <= '0;
            r_active  <= 4'd4;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_issue   <= '0;
            r_left    <= '0;
            r_count   <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_TIME:   r_time   <= i_cfg_data;
                    CFG_ACTIVE: r_active <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            r_rd_vld <= issue;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_s_axis_tuser == OP_LOAD) begin
                            r_state <= ST_LOAD;
                        end else begin
                            r_state <= ST_RUN;
                            r_count <= count;
                            r_left  <= count;
                            r_issue <= '0;
                        end
                    end
                end
                ST_LOAD: r_state <= ST_IDLE;
                ST_RUN: begin
                    if (issue) r_issue <= r_issue + 1'b1;
                    if (terms.valid) r_left <= r_left - 1'b1;
                    if (norm_start) r_state <= ST_NORM;
                end
                ST_NORM: begin
                    if (out_load) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ld_addr  <= WAVE_IDX_W'(in_slot);
            r_ld_field <= in_field;
            r_ld_value <= in_value;
            r_ld_ok    <= slot_ok;
            r_px       <= i_s_axis_tdata[69:38];
            r_pz       <= i_s_axis_tdata[101:70];
            r_sx       <= ACC_W'($signed(i_s_axis_tdata[69:38]));
            r_sz       <= ACC_W'($signed(i_s_axis_tdata[101:70]));
            r_sy       <= '0;
            r_n0       <= '0;
            r_n1       <= ACC_W'(ONE_Q16);
            r_n2       <= '0;
        end else if (terms.valid) begin
            r_sx <= r_sx + ACC_W'(terms.tx);
            r_sy <= r_sy + ACC_W'(terms.ty);
            r_sz <= r_sz + ACC_W'(terms.tz);
            r_n0 <= r_n0 - ACC_W'(terms.ux);
            r_n1 <= r_n1 - ACC_W'(terms.uy);
            r_n2 <= r_n2 - ACC_W'(terms.uz);
        end
        if (out_load) begin
            r_out_data <= {nrm_z, nrm_y, nrm_x, sat_acc(r_sz), sat_acc(r_sy), sat_acc(r_sx)};
        end
    end

    `GWV_ASSERT_IMPL(a_terms_in_run, terms.valid, r_state == ST_RUN)
    `GWV_ASSERT_IMPL(a_norm_in_norm, norm_stat.busy, r_state == ST_NORM)
    `GWV_ASSERT_NEXT(a_result_load, (r_state == ST_NORM) && norm_stat.done && out_free,
                     o_m_axis_tvalid && (r_state == ST_IDLE))
endmodule
`default_nettype wire

// ===== rtl/core/gwv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module gwv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/gwv_wave_pipe.sv =====
// Per-wave term pipeline: phase, sine lookup and the six Q16.16 products.
// Depends on gwv_pkg. Accepts one wave entry per cycle.
`default_nettype none
module gwv_wave_pipe import gwv_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_vld,
    input  wire logic [ENTRY_W-1:0]   i_entry,
    input  wire logic signed [31:0]   i_px,
    input  wire logic signed [31:0]   i_pz,
    input  wire logic [31:0]          i_time,
    output t_wave_terms               o_terms
);
    logic [6:1] r_vld;

    logic signed [31:0] amp, st, dx, dz, fr, rate;
    assign amp  = i_entry[0   +: 32];
    assign st   = i_entry[32  +: 32];
    assign dx   = i_entry[64  +: 32];
    assign dz   = i_entry[96  +: 32];
    assign fr   = i_entry[128 +: 32];
    assign rate = i_entry[160 +: 32];

    // stage 1
    logic signed [63:0] r1_m1, r1_m2;
    logic [31:0]        r1_rt;
    logic signed [31:0] r1_qa, r1_fa, r1_amp, r1_st, r1_dx, r1_dz, r1_fr;
    logic [63:0]        rt_full;
    assign rt_full = rate * i_time;

    // stage 2
    logic [47:0]        r2_s;
    logic [31:0]        r2_rt;
    logic signed [31:0] r2_qdx, r2_qdz, r2_wa, r2_amp, r2_st, r2_dx, r2_dz, r2_fr;
    logic signed [63:0] s_full;
    assign s_full = r1_m1 + r1_m2;

    // stage 3
    logic [47:0]        r3_pl;
    logic [23:0]        r3_ph;
    logic [31:0]        r3_rt;
    logic signed [31:0] r3_qdx, r3_qdz, r3_amp, r3_nx, r3_ny, r3_nz;
    logic signed [56:0] pl_full, ph_full;
    assign pl_full = r2_fr * $signed({1'b0, r2_s[23:0]});
    assign ph_full = r2_fr * $signed({1'b0, r2_s[47:24]});

    // stage 4
    logic [SINE_TABLE_BITS-1:0] r4_k;
    logic signed [31:0]         r4_qdx, r4_qdz, r4_amp, r4_nx, r4_ny, r4_nz;
    logic [47:0]                phase;
    assign phase = r3_pl + {r3_ph, 24'd0} + {r3_rt, 16'd0};

    // stage 5
    logic signed [31:0] r5_sn, r5_cs, r5_qdx, r5_qdz, r5_amp, r5_nx, r5_ny, r5_nz;

    // stage 6
    logic signed [31:0] r6_tx, r6_ty, r6_tz, r6_ux, r6_uy, r6_uz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:1], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_m1  <= dx * i_px;
        r1_m2  <= dz * i_pz;
        r1_rt  <= rt_full[31:0];
        r1_qa  <= qmul(st, amp);
        r1_fa  <= qmul(fr, amp);
        r1_amp <= amp;
        r1_st  <= st;
        r1_dx  <= dx;
        r1_dz  <= dz;
        r1_fr  <= fr;

        r2_s   <= s_full[47:0];
        r2_rt  <= r1_rt;
        r2_qdx <= qmul(r1_qa, r1_dx);
        r2_qdz <= qmul(r1_qa, r1_dz);
        r2_wa  <= qmul(r1_fa, TWO_PI_Q16);
        r2_amp <= r1_amp;
        r2_st  <= r1_st;
        r2_dx  <= r1_dx;
        r2_dz  <= r1_dz;
        r2_fr  <= r1_fr;

        r3_pl  <= pl_full[47:0];
        r3_ph  <= ph_full[23:0];
        r3_rt  <= r2_rt;
        r3_qdx <= r2_qdx;
        r3_qdz <= r2_qdz;
        r3_amp <= r2_amp;
        r3_nx  <= qmul(r2_dx, r2_wa);
        r3_nz  <= qmul(r2_dz, r2_wa);
        r3_ny  <= qmul(r2_st, r2_wa);

        r4_k   <= phase[47 -: SINE_TABLE_BITS];
        r4_qdx <= r3_qdx;
        r4_qdz <= r3_qdz;
        r4_amp <= r3_amp;
        r4_nx  <= r3_nx;
        r4_ny  <= r3_ny;
        r4_nz  <= r3_nz;

        r5_sn  <= 32'(sine_at(r4_k));
        r5_cs  <= 32'(sine_at(r4_k + SINE_TABLE_BITS'(QUARTER)));
        r5_qdx <= r4_qdx;
        r5_qdz <= r4_qdz;
        r5_amp <= r4_amp;
        r5_nx  <= r4_nx;
        r5_ny  <= r4_ny;
        r5_nz  <= r4_nz;

        r6_tx  <= qmul(r5_qdx, r5_cs);
        r6_tz  <= qmul(r5_qdz, r5_cs);
        r6_ty  <= qmul(r5_amp, r5_sn);
        r6_ux  <= qmul(r5_nx, r5_cs);
        r6_uz  <= qmul(r5_nz, r5_cs);
        r6_uy  <= qmul(r5_ny, r5_sn);
    end

    assign o_terms.valid = r_vld[6];
    assign o_terms.tx    = r6_tx;
    assign o_terms.ty    = r6_ty;
    assign o_terms.tz    = r6_tz;
    assign o_terms.ux    = r6_ux;
    assign o_terms.uy    = r6_uy;
    assign o_terms.uz    = r6_uz;
endmodule
`default_nettype wire

// ===== rtl/core/gwv_norm.sv =====
// Normal normalization: power-of-two scaling, sum of squares, serial square
// root and three serial dividers. Depends on gwv_pkg.
`default_nettype none
module gwv_norm import gwv_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [ACC_W-1:0] i_nx,
    input  wire logic signed [ACC_W-1:0] i_ny,
    input  wire logic signed [ACC_W-1:0] i_nz,
    output t_norm_stat                   o_stat,
    output logic signed [15:0]           o_norm_x,
    output logic signed [15:0]           o_norm_y,
    output logic signed [15:0]           o_norm_z
);
    typedef enum logic [5:0] {
        NS_IDLE   = 6'b000001,
        NS_SCALE  = 6'b000010,
        NS_SQUARE = 6'b000100,
        NS_SUM    = 6'b001000,
        NS_ROOT   = 6'b010000,
        NS_DIVIDE = 6'b100000
    } t_nstate;

    t_nstate          r_state;
    logic             r_done;
    logic             r_null;
    logic [4:0]       r_cnt;
    logic [ACC_W-1:0] r_m   [3];
    logic             r_neg [3];
    logic [ACC_W-1:0] r_mx;
    logic [59:0]      r_sq  [3];
    logic [63:0]      r_v;
    logic [63:0]      r_res;
    logic [63:0]      r_bit;
    logic [31:0]      r_len;
    logic [15:0]      r_nlo [3];
    logic [31:0]      r_rem [3];
    logic [15:0]      r_q   [3];

    logic signed [ACC_W-1:0] n_in [3];
    logic [ACC_W-1:0]        m_in [3];
    logic [ACC_W-1:0]        mx_in;
    logic [63:0]             rb;
    logic [32:0]             rem2 [3];
    logic                    big;
    logic                    tiny;
    logic                    seed;
    logic [31:0]             len_next;
    logic [44:0]             num_next [3];

    assign n_in[0] = i_nx;
    assign n_in[1] = i_ny;
    assign n_in[2] = i_nz;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            m_in[j] = n_in[j][ACC_W-1] ? ACC_W'(-n_in[j]) : ACC_W'(n_in[j]);
        end
        mx_in = m_in[0];
        if (m_in[1] > mx_in) mx_in = m_in[1];
        if (m_in[2] > mx_in) mx_in = m_in[2];
    end

    assign big  = (r_mx[ACC_W-1:30] != '0);
    assign tiny = !big && !r_mx[29];
    assign rb   = r_res + r_bit;

    // Last root cycle seeds the dividers; the DIVIDE state then produces the 16 quotient bits.
    assign seed     = (r_state == NS_ROOT) && (r_cnt == '0);
    assign len_next = (r_v >= rb) ? 32'((r_res >> 1) + r_bit) : 32'(r_res >> 1);

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            num_next[j] = {1'b0, r_m[j][29:0], 14'd0} + 45'(len_next[31:1]);
            rem2[j]     = {r_rem[j], r_nlo[j][15]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= NS_IDLE;
            r_done  <= 1'b0;
            r_null  <= 1'b0;
        end else begin
            unique case (r_state)
                NS_IDLE: begin
                    if (i_start) begin
                        r_state <= NS_SCALE;
                        r_done  <= 1'b0;
                        r_null  <= 1'b0;
                    end
                end
                NS_SCALE: begin
                    if (r_mx == '0) begin
                        r_null  <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= NS_IDLE;
                    end else if (!big && !tiny) begin
                        r_state <= NS_SQUARE;
                    end
                end
                NS_SQUARE: r_state <= NS_SUM;
                NS_SUM:    r_state <= NS_ROOT;
                NS_ROOT: begin
                    if (r_cnt == '0) r_state <= NS_DIVIDE;
                end
                NS_DIVIDE: begin
                    if (r_cnt == 5'd16) begin
                        r_done  <= 1'b1;
                        r_state <= NS_IDLE;
                    end
                end
                default: r_state <= NS_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            NS_IDLE: begin
                for (int j = 0; j < 3; j++) begin
                    r_m[j]   <= m_in[j];
                    r_neg[j] <= n_in[j][ACC_W-1];
                end
                r_mx <= mx_in;
            end
            NS_SCALE: begin
                // truncating shifts until the largest lies in [2^29, 2^30)
                if (big) begin
                    for (int j = 0; j < 3; j++) r_m[j] <= r_m[j] >> 1;
                    r_mx <= r_mx >> 1;
                end else if (tiny) begin
                    for (int j = 0; j < 3; j++) r_m[j] <= r_m[j] << 1;
                    r_mx <= r_mx << 1;
                end
            end
            NS_SQUARE: begin
                for (int j = 0; j < 3; j++) r_sq[j] <= r_m[j][29:0] * r_m[j][29:0];
            end
            NS_SUM: begin
                r_v   <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
                r_res <= '0;
                r_bit <= 64'd1 << 62;
                r_cnt <= 5'd31;
            end
            NS_ROOT: begin
                if (r_v >= rb) begin
                    r_v   <= r_v - rb;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                // hold the count at zero for the divide phase
                r_cnt <= (r_cnt == '0) ? 5'd0 : r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    r_len <= len_next;
                end
            end
            NS_DIVIDE: begin
                r_cnt <= r_cnt + 5'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (seed) begin
            for (int j = 0; j < 3; j++) begin
                r_rem[j] <= 32'(num_next[j][44:16]);
                r_nlo[j] <= num_next[j][15:0];
                r_q[j]   <= '0;
            end
        end else if (r_state == NS_DIVIDE && r_cnt != 5'd16) begin
            for (int j = 0; j < 3; j++) begin
                if (rem2[j] >= {1'b0, r_len}) begin
                    r_rem[j] <= 32'(rem2[j] - {1'b0, r_len});
                    r_q[j]   <= {r_q[j][14:0], 1'b1};
                end else begin
                    r_rem[j] <= rem2[j][31:0];
                    r_q[j]   <= {r_q[j][14:0], 1'b0};
                end
                r_nlo[j] <= {r_nlo[j][14:0], 1'b0};
            end
        end
    end

    logic signed [15:0] comp [3];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            comp[j] = r_q[j][15] ? 16'sh7fff : $signed(r_q[j]);
            if (r_neg[j]) comp[j] = -comp[j];
        end
    end

    assign o_norm_x    = r_null ? 16'sd0 : comp[0];
    assign o_norm_y    = r_null ? ONE_Q14 : comp[1];
    assign o_norm_z    = r_null ? 16'sd0 : comp[2];
    assign o_stat.busy = (r_state != NS_IDLE);
    assign o_stat.done = r_done;
endmodule
`default_nettype wire

// ===== verif/gwv_vertex_checker.sv =====
// Checker for the Gerstner wave vertex evaluator: watches the input, config and
// result channels, predicts each vertex result and compares it field by field.
// Depends on gwv_pkg for the channel widths and codes.
`timescale 1ns / 1ps
module gwv_vertex_checker import gwv_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_valid,
    input  wire logic                  i_s_ready,
    input  wire logic [IN_DATA_W-1:0]  i_s_data,
    input  wire logic                  i_s_user,
    input  wire logic                  i_m_valid,
    input  wire logic                  i_m_ready,
    input  wire logic [OUT_DATA_W-1:0] i_m_data,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic                  i_cfg_index,
    input  wire logic [31:0]           i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    localparam int NWAVES  = 8;
    localparam int TBITS   = 10;
    localparam int QTR     = 1 << (TBITS - 2);
    localparam longint unsigned TWO_PI_Q30_V = 64'd6746518852;
    localparam longint TWO_PI_Q16_V = 411775;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } t_vertex;

    longint             quarter_sin [0:QTR];
    logic [31:0]        time_q16;
    logic [3:0]         wave_count;
    logic signed [31:0] amp_tab [NWAVES];
    logic signed [31:0] steep_tab [NWAVES];
    logic signed [31:0] dirx_tab [NWAVES];
    logic signed [31:0] dirz_tab [NWAVES];
    logic signed [31:0] freq_tab [NWAVES];
    logic signed [31:0] rate_tab [NWAVES];
    t_vertex            expected_vertices [$];

    initial begin
        longint unsigned x, x2, t;
        longint unsigned divs [6];
        divs = '{156, 110, 72, 42, 20, 6};
        for (int r = 0; r <= QTR; r++) begin
            x  = (longint'(r) * TWO_PI_Q30_V) >> TBITS;
            x2 = (x * x) >> 30;
            t  = 64'd1 << 30;
            for (int i = 0; i < 6; i++) begin
                t = (64'd1 << 30) - ((x2 * t) >> 30) / divs[i];
            end
            quarter_sin[r] = longint'((((x * t) >> 30) + 64'd8192) >> 14);
        end
    end

    function automatic longint sat_word(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Q16.16 product, round half up, saturate
    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        p = a * b + 64'sd32768;
        return sat_word(p >>> 16);
    endfunction

    function automatic longint sine_lookup(input logic [TBITS-1:0] k);
        logic [1:0] quad;
        int         r;
        longint     v;
        quad = k[TBITS-1 -: 2];
        r    = int'(k[TBITS-3:0]);
        v    = quad[0] ? quarter_sin[QTR - r] : quarter_sin[r];
        return quad[1] ? -v : v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bit_v;
        res   = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v   = v - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic t_vertex displace_vertex(input logic signed [31:0] pos_x,
                                                input logic signed [31:0] pos_z);
        t_vertex         v;
        longint          sx, sy, sz, dx, dz, amp, st, sn, cs, qa, wa;
        longint          n [3];
        longint unsigned m [3];
        longint unsigned s, p, rt, ph, mx, len, q;
        logic [TBITS-1:0] k;
        int              cnt;
        longint          c;
        sx = pos_x; sy = 0; sz = pos_z;
        n  = '{0, 65536, 0};
        cnt = (wave_count > NWAVES) ? NWAVES : int'(wave_count);
        for (int i = 0; i < cnt; i++) begin
            dx  = dirx_tab[i];
            dz  = dirz_tab[i];
            amp = amp_tab[i];
            st  = steep_tab[i];
            s   = longint'(dx * longint'(pos_x)) + longint'(dz * longint'(pos_z));
            p   = longint'(freq_tab[i]) * s;
            rt  = longint'(rate_tab[i]) * longint'({32'd0, time_q16});
            ph  = (p + (rt << 16)) & ((64'd1 << 48) - 1);
            k   = ph[47 -: TBITS];
            sn  = sine_lookup(k);
            cs  = sine_lookup(k + TBITS'(QTR));
            qa  = fx_mul(st, amp);
            wa  = fx_mul(fx_mul(freq_tab[i], amp), TWO_PI_Q16_V);
            sx += fx_mul(fx_mul(qa, dx), cs);
            sz += fx_mul(fx_mul(qa, dz), cs);
            sy += fx_mul(amp, sn);
            n[0] -= fx_mul(fx_mul(dx, wa), cs);
            n[2] -= fx_mul(fx_mul(dz, wa), cs);
            n[1] -= fx_mul(fx_mul(st, wa), sn);
        end
        v.px = 32'(sat_word(sx));
        v.py = 32'(sat_word(sy));
        v.pz = 32'(sat_word(sz));
        mx = 0;
        for (int j = 0; j < 3; j++) begin
            m[j] = (n[j] < 0) ? longint'(-n[j]) : longint'(n[j]);
            if (m[j] > mx) mx = m[j];
        end
        if (mx == 0) begin
            v.nx = 16'sd0; v.ny = 16'sd16384; v.nz = 16'sd0;
            return v;
        end
        // bring the largest magnitude into [2^29, 2^30)
        while (mx >= (64'd1 << 30)) begin
            for (int j = 0; j < 3; j++) m[j] >>= 1;
            mx >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            for (int j = 0; j < 3; j++) m[j] <<= 1;
            mx <<= 1;
        end
        len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int j = 0; j < 3; j++) begin
            q = ((m[j] << 14) + (len >> 1)) / len;
            c = (q > 32767) ? 32767 : longint'(q);
            if (n[j] < 0) c = -c;
            if (j == 0) v.nx = 16'(c);
            else if (j == 1) v.ny = 16'(c);
            else v.nz = 16'(c);
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        logic [2:0]         slot, field;
        logic signed [31:0] value;
        t_vertex            want, got;
        if (!i_rst_n) begin
            time_q16     <= 32'd0;
            wave_count   <= 4'd4;
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_TIME) time_q16 <= i_cfg_data;
                else wave_count <= i_cfg_data[3:0];
            end
            if (i_s_valid && i_s_ready) begin
                slot  = i_s_data[2:0];
                field = i_s_data[5:3];
                value = i_s_data[37:6];
                if (i_s_user == OP_EVAL) begin
                    expected_vertices.push_back(
                        displace_vertex(i_s_data[69:38], i_s_data[101:70]));
                end else begin
                    case (field)
                        FLD_AMP:   amp_tab[slot]   = value;
                        FLD_STEEP: steep_tab[slot] = value;
                        FLD_DIR_X: dirx_tab[slot]  = value;
                        FLD_DIR_Z: dirz_tab[slot]  = value;
                        FLD_FREQ:  freq_tab[slot]  = value;
                        FLD_RATE:  rate_tab[slot]  = value;
                        default: ;
                    endcase
                end
            end
            if (i_m_valid && i_m_ready) begin
                got.px = i_m_data[31:0];
                got.py = i_m_data[63:32];
                got.pz = i_m_data[95:64];
                got.nx = i_m_data[111:96];
                got.ny = i_m_data[127:112];
                got.nz = i_m_data[143:128];
                if (expected_vertices.size() == 0) begin
                    $display("%0t: unexpected vertex result %h", $time, i_m_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_vertices.pop_front();
                    if (got != want) begin
                        $display("%0t: vertex mismatch expected pos %0d %0d %0d nrm %0d %0d %0d",
                                 $time, want.px, want.py, want.pz, want.nx, want.ny, want.nz);
                        $display("%0t:                   actual pos %0d %0d %0d nrm %0d %0d %0d",
                                 $time, got.px, got.py, got.pz, got.nx, got.ny, got.nz);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_vertices.size();
        end
    end
endmodule

// ===== verif/gerstner_wave_vertex_eval_test.sv =====
// Testbench top for the Gerstner wave vertex evaluator: drives loads, vertices
// and register writes with random pacing. Depends on gwv_pkg, gwv_vertex_checker and the evaluator.
`timescale 1ns / 1ps
module gerstner_wave_vertex_eval_test import gwv_pkg::*; ;

    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE     = 160;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic                  s_user = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = 1'b0;
    logic [31:0]           cfg_data = '0;
    int                    fail_count;
    int                    pending;
    int                    idle_cycles = 0;
    bit                    steady = 1'b0;

    always #4 i_clk = ~i_clk;

    gerstner_wave_vertex_eval dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready), .o_m_axis_tdata(m_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    gwv_vertex_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_valid), .i_s_ready(s_ready), .i_s_data(s_data), .i_s_user(s_user),
        .i_m_valid(m_valid), .i_m_ready(m_ready), .i_m_data(m_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("gerstner_wave_vertex_eval test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // result side: random stalls, none while steady
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0 && !steady) begin
                m_ready = 1'b0;
                stall--;
            end else begin
                m_ready = 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic send_word(input logic op, input logic [2:0] slot, input logic [2:0] field,
                             input logic [31:0] value, input logic [31:0] pos_x,
                             input logic [31:0] pos_z);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_user  = op;
        s_data  = {2'b00, pos_z, pos_x, value, field, slot};
        s_valid = 1'b1;
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
    endtask

    task automatic load_wave(input logic [2:0] slot, input logic [2:0] field,
                             input logic [31:0] value);
        send_word(OP_LOAD, slot, field, value, $urandom, $urandom);
    endtask

    task automatic eval_vertex(input logic [31:0] pos_x, input logic [31:0] pos_z);
        send_word(OP_EVAL, 3'($urandom), 3'($urandom), $urandom, pos_x, pos_z);
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // write only once idle; loads may still be in flight after the last result
    task automatic write_reg(input logic idx, input logic [31:0] value);
        drain_results();
        repeat (SETTLE) @(negedge i_clk);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] wave_param();
        if ($urandom_range(0, 5) == 0) return $urandom;
        return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endfunction

    function automatic logic [31:0] vertex_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return $urandom;
        if (r == 3) return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endfunction

    initial begin
        logic [31:0] when_q16;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        write_reg(CFG_ACTIVE, 32'd8);

        // fill the whole table before any vertex reads it
        for (int slot = 0; slot < MAX_WAVES; slot++) begin
            for (int f = 0; f < 6; f++) begin
                load_wave(3'(slot), 3'(f), wave_param());
            end
        end

        // directed: coordinate extremes, unknown fields, wave count extremes
        eval_vertex(32'h0, 32'h0);
        eval_vertex(32'h7fff_ffff, 32'h8000_0000);
        eval_vertex(32'h8000_0000, 32'h7fff_ffff);
        eval_vertex(32'hffff_ffff, 32'h0001_0000);
        load_wave(3'd7, 3'd6, 32'hffff_ffff);
        load_wave(3'd0, 3'd7, 32'h8000_0000);
        load_wave(3'd2, FLD_AMP, 32'h7fff_ffff);
        load_wave(3'd3, FLD_STEEP, 32'h8000_0000);
        eval_vertex(32'h0012_3456, 32'hfff0_0000);
        write_reg(CFG_ACTIVE, 32'd0);
        eval_vertex(32'h1234_5678, 32'h8765_4321);
        write_reg(CFG_ACTIVE, 32'hffff_fff0 | 32'd15);
        write_reg(CFG_TIME, 32'hffff_ffff);
        eval_vertex(32'h0003_0000, 32'hfffd_0000);

        // one wave whose normal sums cancel exactly at a quarter turn
        load_wave(3'd0, FLD_AMP, 32'd65536);
        load_wave(3'd0, FLD_STEEP, 32'd68356);
        load_wave(3'd0, FLD_DIR_X, 32'd0);
        load_wave(3'd0, FLD_DIR_Z, 32'd0);
        load_wave(3'd0, FLD_FREQ, 32'd10000);
        load_wave(3'd0, FLD_RATE, 32'd65536);
        write_reg(CFG_ACTIVE, 32'd1);
        write_reg(CFG_TIME, 32'h0000_4000);
        eval_vertex(32'h0, 32'h0);

        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0: when_q16 = 32'h0;
                1: when_q16 = 32'hffff_ffff;
                default: when_q16 = $urandom;
            endcase
            write_reg(CFG_TIME, when_q16);
            case (phase)
                0: write_reg(CFG_ACTIVE, 32'd8);
                1: write_reg(CFG_ACTIVE, 32'd1);
                2: write_reg(CFG_ACTIVE, 32'd0);
                3: write_reg(CFG_ACTIVE, $urandom & 32'hffff_fff0 | 32'd15);
                default: write_reg(CFG_ACTIVE, $urandom);
            endcase
            steady = (phase == 4);
            for (int n = 0; n < 150; n++) begin
                if (phase == 6 && n == 75) drain_results();
                if ($urandom_range(0, 3) == 0) begin
                    load_wave(3'($urandom), 3'($urandom_range(0, 7)), wave_param());
                end else begin
                    eval_vertex(vertex_coord(), vertex_coord());
                end
            end
            steady = 1'b0;
        end

        drain_results();
        repeat (SETTLE) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("gerstner_wave_vertex_eval test passed");
        end else begin
            $display("gerstner_wave_vertex_eval test failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/gwv_pkg.sv
rtl/core/gwv_ram.sv
rtl/core/gwv_wave_pipe.sv
rtl/core/gwv_norm.sv
rtl/core/gerstner_wave_vertex_eval.sv
verif/gwv_vertex_checker.sv
verif/gerstner_wave_vertex_eval_test.sv
